FILE: rtl/djst_pkg.sv
`default_nettype none

package djst_pkg;

   // justification modes; code 3 behaves as center
   localparam logic [1:0] MODE_LEFT   = 2'd0;
   localparam logic [1:0] MODE_RIGHT  = 2'd1;
   localparam logic [1:0] MODE_CENTER = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_FIRST_DIGIT  = 2'd0;
   localparam logic [1:0] CSR_DIGIT_COUNT  = 2'd1;
   localparam logic [1:0] CSR_JUSTIFY_MODE = 2'd2;
   localparam logic [1:0] CSR_BLANK_CHAR   = 2'd3;

   // reset values of the configuration registers
   localparam logic [5:0] FIRST_DIGIT_RST  = 6'd0;
   localparam logic [3:0] DIGIT_COUNT_RST  = 4'd8;
   localparam logic [1:0] JUSTIFY_MODE_RST = MODE_LEFT;
   localparam logic [7:0] BLANK_CHAR_RST   = 8'd48;

   // blank values below ten are decimal digits shown as ASCII
   localparam logic [7:0] DIGIT_LIMIT = 8'd10;
   localparam logic [7:0] ASCII_ZERO  = 8'd48;

   // usable field size: digit count limited to the buffer depth
   function automatic logic [7:0] field_size(input logic [3:0] count,
                                             input logic [7:0] max_digits);
      logic [7:0] c;
      c = {4'd0, count};
      return (c > max_digits) ? max_digits : c;
   endfunction

   function automatic logic [7:0] fill_char(input logic [7:0] blank);
      return (blank < DIGIT_LIMIT) ? blank + ASCII_ZERO : blank;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/digit_display_justifier_core.sv
// An accepted request passes the command queue and the back-end command register
// before its first digit write is registered. Right/center transactions make n
// digit writes (n = field size, one per cycle from the back-end walker unless the
// receiver stalls); left mode makes one. The front end drops those with no writes.
// Reset (sync, active high): config to defaults, char buffer cleared, queue emptied.
`default_nettype none

module digit_display_justifier_core #(
   parameter int MAX_DIGITS = 8
) (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_position,
   input  logic [6:0] req_char_code,
   input  logic       req_point_on,
   // response channel: one transaction per digit write
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_digit_index,
   output logic [7:0] rsp_out_char,
   output logic       rsp_out_point,
   output logic [7:0] rsp_new_position,
   output logic       rsp_last,
   // config write port
   input  logic       csr_write_en,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int CNT_W = $clog2(MAX_DIGITS + 1);
   localparam int CMD_W = 2 * CNT_W + 2 * IDX_W + 9;

   // config registers; the user must write them only while the block is idle (not enforced)
   logic [5:0] first_digit_ff, first_digit_in;
   logic [3:0] digit_count_ff, digit_count_in;
   logic [1:0] justify_mode_ff, justify_mode_in;
   logic [7:0] blank_char_ff, blank_char_in;

   always_comb begin
      first_digit_in  = first_digit_ff;
      digit_count_in  = digit_count_ff;
      justify_mode_in = justify_mode_ff;
      blank_char_in   = blank_char_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            djst_pkg::CSR_FIRST_DIGIT:  first_digit_in  = csr_wdata[5:0];
            djst_pkg::CSR_DIGIT_COUNT:  digit_count_in  = csr_wdata[3:0];
            djst_pkg::CSR_JUSTIFY_MODE: justify_mode_in = csr_wdata[1:0];
            djst_pkg::CSR_BLANK_CHAR:   blank_char_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_digit_ff  <= djst_pkg::FIRST_DIGIT_RST;
         digit_count_ff  <= djst_pkg::DIGIT_COUNT_RST;
         justify_mode_ff <= djst_pkg::JUSTIFY_MODE_RST;
         blank_char_ff   <= djst_pkg::BLANK_CHAR_RST;
      end else begin
         first_digit_ff  <= first_digit_in;
         digit_count_ff  <= digit_count_in;
         justify_mode_ff <= justify_mode_in;
         blank_char_ff   <= blank_char_in;
      end
   end

   // front end -> command queue -> back end
   logic             q_in_valid;
   logic             q_in_ready;
   logic [CMD_W-1:0] q_in_data;
   logic             q_out_valid;
   logic             q_out_ready;
   logic [CMD_W-1:0] q_out_data;

   // front end: clamps position, works out shift count and leading blanks
   djst_front #(
      .MAX_DIGITS(MAX_DIGITS)
   ) u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_position  (req_position),
      .req_char_code (req_char_code),
      .req_point_on  (req_point_on),
      .digit_count   (digit_count_ff),
      .justify_mode  (justify_mode_ff),
      .q_valid       (q_in_valid),
      .q_ready       (q_in_ready),
      .q_data        (q_in_data)
   );

   // two-deep command queue lets requests land while the field is re-emitted
   djst_queue #(
      .WIDTH(CMD_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_in_valid),
      .in_ready  (q_in_ready),
      .in_data   (q_in_data),
      .out_valid (q_out_valid),
      .out_ready (q_out_ready),
      .out_data  (q_out_data)
   );

   // back end: owns the char buffer, walks the field one digit per cycle unless stalled
   djst_back #(
      .MAX_DIGITS(MAX_DIGITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (q_out_valid),
      .cmd_ready        (q_out_ready),
      .cmd_data         (q_out_data),
      .first_digit      (first_digit_ff),
      .blank_char       (blank_char_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_digit_index  (rsp_digit_index),
      .rsp_out_char     (rsp_out_char),
      .rsp_out_point    (rsp_out_point),
      .rsp_new_position (rsp_new_position),
      .rsp_last         (rsp_last)
   );

`ifndef SYNTHESIS
   // nothing left over from before reset, and the request side opens at once
   a_reset_clean: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("response pending or request blocked after reset");

   // a field walk has no holes until its final write
   a_walk_continuous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid)
      else $error("digit writes of one transaction interrupted");

   // all writes of one transaction carry the same clamped position
   a_walk_position: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=>
         rsp_new_position == $past(rsp_new_position))
      else $error("position changed within one transaction");
`endif

endmodule

`default_nettype wire

FILE: rtl/djst_front.sv
`default_nettype none

module djst_front #(
   parameter int MAX_DIGITS = 8,
   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1,
   localparam int CNT_W = $clog2(MAX_DIGITS + 1),
   localparam int CMD_W = 2 * CNT_W + 2 * IDX_W + 9
) (
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_position,
   input  logic [6:0]       req_char_code,
   input  logic             req_point_on,
   input  logic [3:0]       digit_count,
   input  logic [1:0]       justify_mode,
   output logic             q_valid,
   input  logic             q_ready,
   output logic [CMD_W-1:0] q_data
);

   typedef struct packed {
      logic             is_left;
      logic [CNT_W-1:0] n;
      logic [IDX_W-1:0] pos;
      logic [IDX_W-1:0] shift;
      logic [CNT_W-1:0] lead;
      logic [6:0]       char_code;
      logic             point_on;
   } cmd_type;

   logic [7:0] n8;
   logic       is_left;
   logic       is_right;
   logic       over;
   logic       keep;
   logic [7:0] pos8;
   logic [7:0] shift8;
   logic [7:0] shift_sat;
   logic [7:0] empties8;
   logic [7:0] lead8;
   cmd_type    cmd;

   always_comb begin
      n8       = djst_pkg::field_size(digit_count, 8'(MAX_DIGITS));
      is_left  = (justify_mode == djst_pkg::MODE_LEFT);
      is_right = (justify_mode == djst_pkg::MODE_RIGHT);
      over     = (req_position >= n8);
      // empty field, or left mode past the end: no digit writes
      keep     = (n8 != 8'd0) && !(is_left && over);
      pos8     = over ? n8 - 8'd1 : req_position;
      // steps beyond the end; more than n-1 steps looks the same as n-1
      shift8   = req_position - n8 + 8'd1;
      shift_sat = (shift8 > n8 - 8'd1) ? n8 - 8'd1 : shift8;
      empties8 = n8 - 8'd1 - pos8;
      lead8    = is_right ? empties8 : ((empties8 + 8'd1) >> 1);

      cmd.is_left   = is_left;
      cmd.n         = CNT_W'(n8);
      cmd.pos       = IDX_W'(pos8);
      cmd.shift     = over ? IDX_W'(shift_sat) : '0;
      cmd.lead      = CNT_W'(lead8);
      cmd.char_code = req_char_code;
      cmd.point_on  = req_point_on;
   end

   assign req_ready = q_ready;
   assign q_valid   = req_valid && keep;
   assign q_data    = cmd;

endmodule

`default_nettype wire

FILE: rtl/djst_queue.sv
`default_nettype none

module djst_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   // two-entry queue: head is read, tail takes overflow
   logic [WIDTH-1:0] head_ff, head_in;
   logic [WIDTH-1:0] tail_ff, tail_in;
   logic             head_valid_ff, head_valid_in;
   logic             tail_valid_ff, tail_valid_in;
   logic             push;
   logic             pop;

   assign in_ready  = !tail_valid_ff;
   assign out_valid = head_valid_ff;
   assign out_data  = head_ff;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      head_valid_in = head_valid_ff;
      tail_valid_in = tail_valid_ff;
      if (pop) begin
         if (tail_valid_ff) begin
            head_in       = tail_ff;
            tail_valid_in = 1'b0;
         end else begin
            head_in       = in_data;
            head_valid_in = push;
         end
      end else if (push) begin
         if (!head_valid_ff) begin
            head_in       = in_data;
            head_valid_in = 1'b1;
         end else begin
            tail_in       = in_data;
            tail_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
      if (reset) begin
         head_valid_ff <= 1'b0;
         tail_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         tail_valid_ff <= tail_valid_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/djst_back.sv
`default_nettype none

module djst_back #(
   parameter int MAX_DIGITS = 8,
   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1,
   localparam int CNT_W = $clog2(MAX_DIGITS + 1),
   localparam int CMD_W = 2 * CNT_W + 2 * IDX_W + 9
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  logic [CMD_W-1:0] cmd_data,
   input  logic [5:0]       first_digit,
   input  logic [7:0]       blank_char,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [6:0]       rsp_digit_index,
   output logic [7:0]       rsp_out_char,
   output logic             rsp_out_point,
   output logic [7:0]       rsp_new_position,
   output logic             rsp_last
);

   typedef struct packed {
      logic             is_left;
      logic [CNT_W-1:0] n;
      logic [IDX_W-1:0] pos;
      logic [IDX_W-1:0] shift;
      logic [CNT_W-1:0] lead;
      logic [6:0]       char_code;
      logic             point_on;
   } cmd_type;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EMIT = 1'b1;
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

   logic             state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   cmd_type          new_cmd;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [7:0]       chbuf_ff [MAX_DIGITS];
   logic [7:0]       chbuf_in [MAX_DIGITS];

   logic             rsp_valid_ff, rsp_valid_in;
   logic [6:0]       digit_index_ff, digit_index_in;
   logic [7:0]       out_char_ff, out_char_in;
   logic             out_point_ff, out_point_in;
   logic [7:0]       new_position_ff, new_position_in;
   logic             last_ff, last_in;

   logic             emit_go;
   logic             is_last;
   logic             pop;
   logic [CNT_W:0]   j_ext;
   logic [CNT_W:0]   lead_ext;
   logic [CNT_W:0]   hi_ext;
   logic             in_win;
   logic [IDX_W-1:0] rel;
   logic [7:0]       entry;

   assign new_cmd = cmd_type'(cmd_data);

   // one digit write per cycle while the output register drains
   assign emit_go   = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign is_last   = cmd_ff.is_left || (CNT_W'(j_ff) == cmd_ff.n - CNT_ONE);
   assign cmd_ready = (state_ff == ST_IDLE) || (emit_go && is_last);
   assign pop       = cmd_valid && cmd_ready;

   // buffer update: k shifts leave entry x = old[min(x + k, n - 1)], then pos takes the new char
   always_comb begin
      logic [CNT_W:0] src;
      logic [CNT_W:0] top_idx;
      src     = '0;
      top_idx = {1'b0, new_cmd.n} - {{CNT_W{1'b0}}, 1'b1};
      for (int x = 0; x < MAX_DIGITS; x++) begin
         chbuf_in[x] = chbuf_ff[x];
         if ((CNT_W + 1)'(x) < {1'b0, new_cmd.n}) begin
            src = (CNT_W + 1)'(x) + (CNT_W + 1)'(new_cmd.shift);
            if (src > top_idx) begin
               src = top_idx;
            end
            chbuf_in[x] = chbuf_ff[IDX_W'(src)];
            if (IDX_W'(x) == new_cmd.pos) begin
               chbuf_in[x] = {new_cmd.point_on, new_cmd.char_code};
            end
         end
      end
   end

   // field walk: leading blanks, buffer window, trailing blanks; left mode sends the char itself
   always_comb begin
      j_ext    = (CNT_W + 1)'(j_ff);
      lead_ext = (CNT_W + 1)'(cmd_ff.lead);
      hi_ext   = lead_ext + (CNT_W + 1)'(cmd_ff.pos);
      in_win   = (j_ext >= lead_ext) && (j_ext <= hi_ext);
      rel      = IDX_W'(j_ext - lead_ext);
      entry    = chbuf_ff[rel];

      digit_index_in  = 7'(first_digit) + 7'(j_ff);
      new_position_in = 8'(cmd_ff.pos);
      last_in         = is_last;
      if (cmd_ff.is_left) begin
         out_char_in  = {1'b0, cmd_ff.char_code};
         out_point_in = cmd_ff.point_on;
      end else if (in_win) begin
         out_char_in  = {1'b0, entry[6:0]};
         out_point_in = entry[7];
      end else begin
         out_char_in  = djst_pkg::fill_char(blank_char);
         out_point_in = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      j_in     = j_ff;
      unique case (state_ff)
         ST_IDLE: state_in = ST_IDLE;
         ST_EMIT: begin
            if (emit_go) begin
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  j_in = IDX_W'(j_ff + 1'b1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // next command is taken in the cycle of the final write
      if (pop) begin
         state_in = ST_EMIT;
         cmd_in   = new_cmd;
         j_in     = new_cmd.is_left ? new_cmd.pos : '0;
      end
      if (emit_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      j_ff   <= j_in;
      if (emit_go) begin
         digit_index_ff  <= digit_index_in;
         out_char_ff     <= out_char_in;
         out_point_ff    <= out_point_in;
         new_position_ff <= new_position_in;
         last_ff         <= last_in;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int x = 0; x < MAX_DIGITS; x++) begin
            chbuf_ff[x] <= 8'd0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (pop && !new_cmd.is_left) begin
            for (int x = 0; x < MAX_DIGITS; x++) begin
               chbuf_ff[x] <= chbuf_in[x];
            end
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_digit_index  = digit_index_ff;
   assign rsp_out_char     = out_char_ff;
   assign rsp_out_point    = out_point_ff;
   assign rsp_new_position = new_position_ff;
   assign rsp_last         = last_ff;

endmodule

`default_nettype wire

FILE: verif/digit_display_justifier_core_tb.sv
`default_nettype none

module digit_display_justifier_core_tb;

   localparam int BUF_DEPTH = 8;
   // code 3 is not named in the package; the block treats it as center
   localparam logic [1:0] MODE_ALT_CENTER = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   // settle time after the last digit write, before the next register setup
   localparam int SETTLE_CYCLES = 12;
   localparam int SEGMENTS_PER_PHASE = 7;
   localparam int ITEMS_PER_SEGMENT = 12;

   // one expected digit write
   typedef struct packed {
      logic [6:0] digit;
      logic [7:0] chr;
      logic       pt;
      logic [7:0] pos;
      logic       last;
   } digit_write_type;

   // Field shadow: mirrors registers and the character buffer, turns each
   // accepted character into the digit writes it must cause, and checks
   // the writes in order.
   class digit_field_scoreboard;
      logic [7:0]      char_buf [BUF_DEPTH];
      logic [5:0]      first_digit;
      logic [3:0]      digit_count;
      logic [1:0]      justify_mode;
      logic [7:0]      blank_char;
      digit_write_type pending_writes [$];
      int              failures;
      int              writes_checked;
      int              chars_taken;

      function new();
         foreach (char_buf[i]) char_buf[i] = '0;
         first_digit    = djst_pkg::FIRST_DIGIT_RST;
         digit_count    = djst_pkg::DIGIT_COUNT_RST;
         justify_mode   = djst_pkg::JUSTIFY_MODE_RST;
         blank_char     = djst_pkg::BLANK_CHAR_RST;
         failures       = 0;
         writes_checked = 0;
         chars_taken    = 0;
      endfunction

      function void set_register(logic [1:0] idx, logic [7:0] data);
         case (idx)
            djst_pkg::CSR_FIRST_DIGIT:  first_digit  = data[5:0];
            djst_pkg::CSR_DIGIT_COUNT:  digit_count  = data[3:0];
            djst_pkg::CSR_JUSTIFY_MODE: justify_mode = data[1:0];
            djst_pkg::CSR_BLANK_CHAR:   blank_char   = data;
            default: ;
         endcase
      endfunction

      function void note_char(logic [7:0] pos_in, logic [6:0] ch, logic pt);
         int              n;
         int              pos;
         int              empties;
         int              leading;
         int              x;
         logic [7:0]      fill;
         logic [7:0]      v;
         digit_write_type w;
         chars_taken++;
         n = (digit_count > BUF_DEPTH) ? BUF_DEPTH : digit_count;
         if (n == 0)
            return;
         fill = (blank_char < djst_pkg::DIGIT_LIMIT) ?
                blank_char + djst_pkg::ASCII_ZERO : blank_char;
         pos = pos_in;

         // left: straight to the digit, dropped past the field
         if (justify_mode == djst_pkg::MODE_LEFT) begin
            if (pos < n) begin
               w.digit = 7'(first_digit + pos);
               w.chr   = {1'b0, ch};
               w.pt    = pt;
               w.pos   = pos_in;
               w.last  = 1'b1;
               pending_writes.push_back(w);
            end
            return;
         end

         // past the end: scroll the buffer left one step per overshoot
         while (pos >= n) begin
            for (x = 0; x + 1 < n; x++)
               char_buf[x] = char_buf[x + 1];
            pos--;
         end
         char_buf[pos] = {pt, ch};

         empties = n - pos - 1;
         leading = (justify_mode == djst_pkg::MODE_RIGHT) ?
                   empties : (empties + 1) / 2;
         for (x = 0; x < n; x++) begin
            if (x < leading || x > leading + pos) begin
               w.chr = fill;
               w.pt  = 1'b0;
            end else begin
               v     = char_buf[x - leading];
               w.chr = {1'b0, v[6:0]};
               w.pt  = v[7];
            end
            w.digit = 7'(first_digit + x);
            w.pos   = 8'(pos);
            w.last  = (x == n - 1);
            pending_writes.push_back(w);
         end
      endfunction

      function void check_result(logic [6:0] digit, logic [7:0] chr, logic pt,
                                 logic [7:0] pos, logic last);
         digit_write_type w;
         if (pending_writes.size() == 0) begin
            $error("unexpected digit write: digit_index %0d out_char %0d", digit, chr);
            failures++;
            return;
         end
         w = pending_writes.pop_front();
         writes_checked++;
         if (digit !== w.digit) begin
            $error("digit_index: expected %0d, got %0d", w.digit, digit);
            failures++;
         end
         if (chr !== w.chr) begin
            $error("out_char: expected %0d, got %0d", w.chr, chr);
            failures++;
         end
         if (pt !== w.pt) begin
            $error("out_point: expected %0d, got %0d", w.pt, pt);
            failures++;
         end
         if (pos !== w.pos) begin
            $error("new_position: expected %0d, got %0d", w.pos, pos);
            failures++;
         end
         if (last !== w.last) begin
            $error("last: expected %0d, got %0d", w.last, last);
            failures++;
         end
      endfunction
   endclass

   logic       clock;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic       req_ready;
   logic [7:0] req_position  = '0;
   logic [6:0] req_char_code = '0;
   logic       req_point_on  = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready     = 1'b0;
   logic [6:0] rsp_digit_index;
   logic [7:0] rsp_out_char;
   logic       rsp_out_point;
   logic [7:0] rsp_new_position;
   logic       rsp_last;
   logic       csr_write_en  = 1'b0;
   logic [1:0] csr_index     = '0;
   logic [7:0] csr_wdata     = '0;

   digit_field_scoreboard sb;

   // idle odds in percent per cycle, set by the stimulus phases
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   // long receiver hold-off: stimulus bumps hold_tag, receiver counts it down
   int hold_tag     = 0;
   int hold_len     = 0;
   int hold_seen    = 0;
   int hold_left    = 0;
   int reg_writes   = 0;
   int cycle_count  = 0;

   digit_display_justifier_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_position     (req_position),
      .req_char_code    (req_char_code),
      .req_point_on     (req_point_on),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_digit_index  (rsp_digit_index),
      .rsp_out_char     (rsp_out_char),
      .rsp_out_point    (rsp_out_point),
      .rsp_new_position (rsp_new_position),
      .rsp_last         (rsp_last),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("digit_display_justifier_core verification failed");
         $finish;
      end
   end

   // Receiver: checks each digit-write transaction at the edge it is taken,
   // then picks ready for the next cycle (random stalls or a long hold-off).
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_digit_index, rsp_out_char, rsp_out_point,
                            rsp_new_position, rsp_last);
         if (hold_tag != hold_seen) begin
            hold_seen = hold_tag;
            hold_left = hold_len;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Offer one character; returns at the edge where the transaction is taken,
   // with valid still high so a back-to-back offer follows with no gap.
   task automatic send_char(input logic [7:0] pos, input logic [6:0] ch,
                            input logic pt);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_position  <= pos;
      req_char_code <= ch;
      req_point_on  <= pt;
      do @(posedge clock); while (!req_ready);
      sb.note_char(pos, ch, pt);
   endtask

   // sender quiet until every expected digit write has come out
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_writes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      sb.set_register(idx, data);
      reg_writes++;
   endtask

   task automatic configure(input logic [5:0] fd, input logic [3:0] cnt,
                            input logic [1:0] mode, input logic [7:0] blank);
      write_reg(djst_pkg::CSR_FIRST_DIGIT, {2'b00, fd});
      write_reg(djst_pkg::CSR_DIGIT_COUNT, {4'h0, cnt});
      write_reg(djst_pkg::CSR_JUSTIFY_MODE, {6'h00, mode});
      write_reg(djst_pkg::CSR_BLANK_CHAR, blank);
   endtask

   // Mostly a caller typing a line: positions count up and run a little past
   // the field so right/center scroll; the rest are random jumps.
   task automatic send_line(input int items, input int cnt);
      int         seq_pos;
      int         sel;
      logic [7:0] pos;
      seq_pos = 0;
      repeat (items) begin
         sel = $urandom_range(9);
         if (sel < 7) begin
            pos = 8'(seq_pos);
            seq_pos++;
            if (seq_pos > cnt + 2)
               seq_pos = 0;
         end else if (sel == 7) begin
            pos = 8'($urandom_range(255));
         end else begin
            pos = 8'($urandom_range(15));
         end
         send_char(pos, 7'($urandom_range(127)), 1'($urandom_range(1)));
      end
   endtask

   // new random field setup, extremes weighted in, then one line of text
   task automatic run_random_segment(input int items);
      logic [5:0] fd;
      logic [3:0] cnt;
      logic [7:0] blank;
      case ($urandom_range(3))
         0:       fd = 6'd0;
         1:       fd = 6'd63;
         default: fd = 6'($urandom_range(63));
      endcase
      case ($urandom_range(9))
         0:       cnt = 4'd0;
         1:       cnt = 4'($urandom_range(15, 9));
         2:       cnt = 4'd8;
         3:       cnt = 4'd1;
         default: cnt = 4'($urandom_range(8, 1));
      endcase
      case ($urandom_range(4))
         0:       blank = 8'($urandom_range(9));
         1:       blank = 8'd255;
         default: blank = 8'($urandom_range(255));
      endcase
      wait_drained();
      configure(fd, cnt, 2'($urandom_range(3)), blank);
      send_line(items, cnt);
   endtask

   initial begin
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed ----
      // reset setup: left, 8 digits from digit 0; in range, last digit, dropped
      send_char(8'd0, 7'h7F, 1'b1);
      send_char(8'd7, 7'h00, 1'b0);
      send_char(8'd8, 7'h41, 1'b1);
      send_char(8'd255, 7'h2A, 1'b0);

      // right at the top digit, blank below ten shown as an ASCII digit;
      // fill the field, overshoot by one, then by a long way
      wait_drained();
      configure(6'd63, 4'd8, djst_pkg::MODE_RIGHT, 8'd0);
      send_char(8'd0, 7'h31, 1'b0);
      send_char(8'd1, 7'h32, 1'b1);
      send_char(8'd7, 7'h7F, 1'b1);
      send_char(8'd8, 7'h00, 1'b0);
      send_char(8'd255, 7'h55, 1'b1);

      // center with odd empties (leading blanks round up)
      wait_drained();
      configure(6'd0, 4'd5, djst_pkg::MODE_CENTER, 8'd9);
      send_char(8'd0, 7'h41, 1'b0);
      send_char(8'd1, 7'h42, 1'b1);
      send_char(8'd2, 7'h43, 1'b0);
      send_char(8'd4, 7'h44, 1'b1);
      send_char(8'd200, 7'h45, 1'b0);

      // mode code 3 must act as center
      wait_drained();
      configure(6'd20, 4'd3, MODE_ALT_CENTER, 8'd255);
      send_char(8'd0, 7'h61, 1'b1);
      send_char(8'd1, 7'h62, 1'b0);
      send_char(8'd5, 7'h63, 1'b1);

      // empty field: no writes in right or left mode
      wait_drained();
      configure(6'd0, 4'd0, djst_pkg::MODE_RIGHT, 8'd48);
      send_char(8'd0, 7'h30, 1'b1);
      wait_drained();
      write_reg(djst_pkg::CSR_JUSTIFY_MODE, {6'h00, djst_pkg::MODE_LEFT});
      send_char(8'd0, 7'h30, 1'b1);

      // count beyond the buffer clamps to eight; blank of exactly ten is literal
      wait_drained();
      configure(6'd40, 4'd15, djst_pkg::MODE_RIGHT, 8'd10);
      send_char(8'd3, 7'h5A, 1'b0);
      send_char(8'd9, 7'h5B, 1'b1);

      // single-digit field
      wait_drained();
      configure(6'd63, 4'd1, djst_pkg::MODE_CENTER, 8'd32);
      send_char(8'd0, 7'h21, 1'b1);
      send_char(8'd7, 7'h22, 1'b0);

      // left edge of the field boundary
      wait_drained();
      configure(6'd1, 4'd4, djst_pkg::MODE_LEFT, 8'd48);
      send_char(8'd3, 7'h70, 1'b0);
      send_char(8'd4, 7'h71, 1'b1);

      // ---- phase A: sender idles a little, receiver often ----
      req_idle_pct = 9;
      rsp_idle_pct = 48;
      // back-pressure: receiver frozen while a full right-justified field is
      // fed, so the block fills and must stall its request side
      wait_drained();
      configure(6'($urandom_range(63)), 4'd8, djst_pkg::MODE_RIGHT,
                8'($urandom_range(255)));
      hold_len = 300;
      hold_tag++;
      send_line(16, 8);
      repeat (SEGMENTS_PER_PHASE - 1) run_random_segment(ITEMS_PER_SEGMENT);

      // ---- phase B: roles swapped ----
      req_idle_pct = 48;
      rsp_idle_pct = 9;
      repeat (SEGMENTS_PER_PHASE) run_random_segment(ITEMS_PER_SEGMENT);

      // ---- phase C: full rate both ways ----
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      repeat (SEGMENTS_PER_PHASE) run_random_segment(ITEMS_PER_SEGMENT);

      wait_drained();
      if (sb.pending_writes.size() != 0) begin
         $error("%0d expected digit writes never arrived", sb.pending_writes.size());
         sb.failures++;
      end

      $display("Run covered %0d characters and %0d digit writes across left, right,",
               sb.chars_taken, sb.writes_checked);
      $display("center and mode-3 fields, %0d register writes, stalls on both sides.",
               reg_writes);
      if (sb.failures == 0) begin
         $display("digit_display_justifier_core verification clean");
      end else begin
         $display("digit_display_justifier_core verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: files.f
rtl/djst_pkg.sv
rtl/djst_front.sv
rtl/djst_queue.sv
rtl/djst_back.sv
rtl/digit_display_justifier_core.sv
verif/digit_display_justifier_core_tb.sv
